// ----- design/vibrato_modulated_delay_core_defines.svh -----
// Assertion macros shared by the vibrato delay RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef VIBRATO_MODULATED_DELAY_CORE_DEFINES_SVH
`define VIBRATO_MODULATED_DELAY_CORE_DEFINES_SVH

// Same-cycle property, checked out of reset.
`define VMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define VMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vmd_pkg.sv -----
// Shared widths, constants and types for the vibrato modulated delay.
// No dependencies.
`default_nettype none

package vmd_pkg;

  localparam int unsigned MAX_DELAY_DEF    = 3840;
  localparam int unsigned MAX_CHANNELS_DEF = 8;

  localparam int unsigned DATA_W   = 24;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned LFO_W    = 16;
  localparam int unsigned SR_W     = 18;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned DEPTH_W  = 17;
  localparam int unsigned FRAC_W   = 16;

  // base = floor(rate * 8192 / 25), split as q*8192 + floor(r*8192/25)
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP25 = 20'd671089;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned Q_W         = 14;
  localparam int unsigned FR_W        = 13;
  localparam int unsigned REM_W       = 5;
  localparam int unsigned BASE_W      = Q_W + FR_W;
  localparam int unsigned SWEEP_W     = 28;
  localparam int unsigned SCALED_W    = 29;
  localparam int unsigned DLY_W       = 31;

  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned RIDX_W  = 2;

  localparam logic [RIDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [RIDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [RIDX_W-1:0] REG_DEPTH         = 2'd2;

  localparam logic [SR_W-1:0]    SAMPLE_RATE_RST   = 18'd44100;
  localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST = 4'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_RST         = 17'd32768;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   act;
    logic               clear;
  } cfg_t;

endpackage

`default_nettype wire

// ----- design/vmd_if.sv -----
// Valid/ready channel interfaces for sample input and output.
// Depends on vmd_pkg for field widths.
`default_nettype none

interface vmd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vmd_pkg::DATA_W-1:0]   sample_in;
  logic        [vmd_pkg::CHAN_W-1:0]   channel;
  logic signed [vmd_pkg::LFO_W-1:0]    lfo_value;

  modport source (output valid, output sample_in, output channel, output lfo_value,
                  input ready);
  modport sink   (input valid, input sample_in, input channel, input lfo_value,
                  output ready);
endinterface

interface vmd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vmd_pkg::DATA_W-1:0]   sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- design/vmd_store.sv -----
// Delay store: one write port, two registered read ports.
// No dependencies beyond its parameters.
`default_nettype none

module vmd_store #(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned WIDTH  = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]  rdata_a_o,
  output logic      [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- design/vmd_cfg.sv -----
// APB register file (rate, channel count, depth) and base delay pipeline.
// Depends on vmd_pkg.
`default_nettype none

module vmd_cfg #(
  parameter int unsigned MAX_CHANNELS = vmd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vmd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vmd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [vmd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output vmd_pkg::cfg_t                     cfg_o
);

  logic [vmd_pkg::SR_W-1:0]    sr_q;
  logic [vmd_pkg::CNT_W-1:0]   cnt_q;
  logic [vmd_pkg::DEPTH_W-1:0] depth_q;
  logic [vmd_pkg::RIDX_W-1:0]  ridx;
  logic                        wr;
  logic                        clear;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign ridx   = paddr[vmd_pkg::PADDR_W-1:vmd_pkg::PADDR_W-vmd_pkg::RIDX_W];

  always_comb begin
    clear = 1'b0;
    if (wr) begin
      unique case (ridx)
        vmd_pkg::REG_SAMPLE_RATE:   clear = (pwdata[vmd_pkg::SR_W-1:0] != sr_q);
        vmd_pkg::REG_CHANNEL_COUNT: clear = (pwdata[vmd_pkg::CNT_W-1:0] != cnt_q);
        default:                    clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= vmd_pkg::SAMPLE_RATE_RST;
      cnt_q   <= vmd_pkg::CHANNEL_COUNT_RST;
      depth_q <= vmd_pkg::DEPTH_RST;
    end else if (wr) begin
      unique case (ridx)
        vmd_pkg::REG_SAMPLE_RATE:   sr_q    <= pwdata[vmd_pkg::SR_W-1:0];
        vmd_pkg::REG_CHANNEL_COUNT: cnt_q   <= pwdata[vmd_pkg::CNT_W-1:0];
        vmd_pkg::REG_DEPTH:         depth_q <= pwdata[vmd_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      vmd_pkg::REG_SAMPLE_RATE:   prdata = vmd_pkg::PDATA_W'(sr_q);
      vmd_pkg::REG_CHANNEL_COUNT: prdata = vmd_pkg::PDATA_W'(cnt_q);
      vmd_pkg::REG_DEPTH:         prdata = vmd_pkg::PDATA_W'(depth_q);
      default:                    prdata = '0;
    endcase
  end

  // base delay in Q.16: three stages, settles long before the clearing pass ends
  localparam int unsigned PROD_W = vmd_pkg::SR_W + vmd_pkg::RECIP_W;

  logic [PROD_W-1:0]          qprod;
  logic [PROD_W-1:0]          rprod;
  logic [vmd_pkg::SR_W-1:0]   q25;
  logic [vmd_pkg::SR_W-1:0]   rem_full;
  logic [vmd_pkg::SR_W-1:0]   rem_sh;
  logic [vmd_pkg::Q_W-1:0]    q1_q, q2_q;
  logic [vmd_pkg::SR_W-1:0]   sr1_q;
  logic [vmd_pkg::FR_W-1:0]   fr_q;
  logic [vmd_pkg::BASE_W-1:0] base_q;

  assign qprod    = PROD_W'(sr_q) * PROD_W'(vmd_pkg::RECIP25);
  assign q25      = (vmd_pkg::SR_W'(q1_q) << 4) + (vmd_pkg::SR_W'(q1_q) << 3)
                  + vmd_pkg::SR_W'(q1_q);
  assign rem_full = sr1_q - q25;
  assign rem_sh   = {rem_full[vmd_pkg::REM_W-1:0], {vmd_pkg::FR_W{1'b0}}};
  assign rprod    = PROD_W'(rem_sh) * PROD_W'(vmd_pkg::RECIP25);

  always_ff @(posedge clk_i) begin
    q1_q   <= qprod[vmd_pkg::RECIP_SHIFT +: vmd_pkg::Q_W];
    sr1_q  <= sr_q;
    q2_q   <= q1_q;
    fr_q   <= rprod[vmd_pkg::RECIP_SHIFT +: vmd_pkg::FR_W];
    base_q <= {q2_q, {vmd_pkg::FR_W{1'b0}}} + vmd_pkg::BASE_W'(fr_q);
  end

  assign cfg_o.base  = base_q;
  assign cfg_o.depth = depth_q;
  assign cfg_o.act   = (cnt_q >= vmd_pkg::CNT_W'(MAX_CHANNELS))
                       ? vmd_pkg::CNT_W'(MAX_CHANNELS) : cnt_q;
  assign cfg_o.clear = clear;

endmodule

`default_nettype wire

// ----- design/vibrato_modulated_delay_core.sv -----
// An active-channel sample steps through the multiply, clamp, read, interpolate and
// output states; no new sample is taken until its result is loaded for output.
// Inactive-channel samples pass from idle straight to the output state.
// Reset, and any change of the rate or channel count, starts a clearing pass that zeroes
// all 2**(channel bits + position bits) store words (32768 at defaults), input not ready.
`default_nettype none
`include "vibrato_modulated_delay_core_defines.svh"

module vibrato_modulated_delay_core #(
  parameter int unsigned MAX_DELAY    = vmd_pkg::MAX_DELAY_DEF,
  parameter int unsigned MAX_CHANNELS = vmd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  vmd_in_if.sink                            in_i,
  vmd_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vmd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vmd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [vmd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned POS_W  = $clog2(MAX_DELAY);
  localparam int unsigned CHI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ADDR_W = CHI_W + POS_W;
  localparam int unsigned DW     = vmd_pkg::DATA_W;
  localparam int unsigned PW     = DW + 1 + vmd_pkg::FRAC_W + 1;
  localparam int unsigned YW     = PW - vmd_pkg::FRAC_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_DELAY = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic signed [vmd_pkg::DLY_W-1:0] DLY_LO = vmd_pkg::DLY_W'(1 << 16);
  localparam logic signed [vmd_pkg::DLY_W-1:0] DLY_HI =
    vmd_pkg::DLY_W'((MAX_DELAY - 1) << 16);
  localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (DW - 1)) - 1);
  localparam logic signed [YW-1:0] Y_MIN = -YW'(1 << (DW - 1));

  vmd_pkg::cfg_t cfg;

  vmd_cfg #(.MAX_CHANNELS(MAX_CHANNELS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [2:0]        state_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [POS_W-1:0]  wp_q;
  logic [POS_W-1:0]  wp_next;
  logic              out_valid_q;
  logic [DW-1:0]     out_data_q;

  logic              in_ready;
  logic              in_fire;
  logic              in_active;
  logic              out_load;

  logic signed [DW-1:0]              x_q;
  logic [vmd_pkg::CHAN_W-1:0]        ch_q;
  logic signed [vmd_pkg::LFO_W-1:0]  lfo_q;
  logic                              bypass_q;
  logic                              last_q;
  logic [vmd_pkg::SWEEP_W-1:0]       sweep_q;
  logic [vmd_pkg::SCALED_W-1:0]      scaled_q;
  logic [POS_W-1:0]                  d_q;
  logic [vmd_pkg::FRAC_W-1:0]        f_q;
  logic signed [DW-1:0]              a_q;
  logic signed [PW-1:0]              prod_q;

  localparam int unsigned SPROD_W = vmd_pkg::BASE_W + vmd_pkg::DEPTH_W;
  logic [SPROD_W-1:0]                swp_prod;
  logic [SPROD_W-1:0]                scl_prod;
  logic [vmd_pkg::LFO_W-1:0]         lfo_bias;
  logic signed [vmd_pkg::DLY_W-1:0]  dly;
  logic [POS_W:0]                    pdiff;
  logic [POS_W-1:0]                  p1, p2;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [DW-1:0]     st_wdata;
  logic [DW-1:0]     rd_a, rd_b;
  logic signed [DW:0]   ba_diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rounded;
  logic signed [YW-1:0] y_full;
  logic [DW-1:0]        y_sat;
  logic [DW-1:0]        res;

  assign in_ready    = (state_q == ST_IDLE) && !clr_busy_q;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign in_active   = ({1'b0, in_i.channel} < cfg.act);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.sample_out = out_data_q;

  assign wp_next = (wp_q == POS_W'(MAX_DELAY - 1)) ? '0 : wp_q + 1'b1;

  // store write: clearing sweep or the incoming sample
  assign st_we    = clr_busy_q || (in_fire && in_active);
  assign st_waddr = clr_busy_q ? clr_cnt_q : {in_i.channel[CHI_W-1:0], wp_q};
  assign st_wdata = clr_busy_q ? '0 : in_i.sample_in;

  vmd_store #(.ADDR_W(ADDR_W), .WIDTH(DW)) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (st_waddr),
    .wdata_i   (st_wdata),
    .raddr_a_i ({ch_q[CHI_W-1:0], p1}),
    .raddr_b_i ({ch_q[CHI_W-1:0], p2}),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // delay arithmetic
  assign swp_prod = SPROD_W'(cfg.base) * SPROD_W'(cfg.depth);
  assign lfo_bias = {~lfo_q[vmd_pkg::LFO_W-1], lfo_q[vmd_pkg::LFO_W-2:0]};
  assign scl_prod = SPROD_W'(sweep_q) * SPROD_W'(lfo_bias);
  assign dly = $signed(vmd_pkg::DLY_W'(cfg.base)) + $signed(vmd_pkg::DLY_W'(scaled_q))
             - $signed(vmd_pkg::DLY_W'(sweep_q));

  assign pdiff = {1'b0, wp_q} - {1'b0, d_q};
  assign p1    = pdiff[POS_W] ? pdiff[POS_W-1:0] + POS_W'(MAX_DELAY) : pdiff[POS_W-1:0];
  assign p2    = (p1 == '0) ? POS_W'(MAX_DELAY - 1) : p1 - 1'b1;

  // interpolation: a + round((b - a) * f / 2^16), ties up
  assign ba_diff = $signed({rd_b[DW-1], rd_b}) - $signed({rd_a[DW-1], rd_a});
  assign prod    = PW'(ba_diff) * $signed({1'b0, f_q});
  assign rounded = prod_q + PW'(1 << (vmd_pkg::FRAC_W - 1));
  assign y_full  = YW'(a_q) + rounded[PW-1:vmd_pkg::FRAC_W];
  assign y_sat   = (y_full > Y_MAX) ? DW'(Y_MAX)
                 : (y_full < Y_MIN) ? DW'(Y_MIN) : y_full[DW-1:0];
  assign res     = bypass_q ? x_q : y_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= in_active ? ST_SCALE : ST_OUT;
          end
        end
        ST_SCALE: state_q <= ST_DELAY;
        ST_DELAY: state_q <= ST_ADDR;
        ST_ADDR:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.clear) begin
        clr_busy_q <= 1'b1;
        clr_cnt_q  <= '0;
        wp_q       <= '0;
      end else begin
        if (out_load && !bypass_q && last_q) begin
          wp_q <= wp_next;
        end
        if (clr_busy_q) begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == '1) begin
            clr_busy_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q      <= in_i.sample_in;
      ch_q     <= in_i.channel;
      lfo_q    <= in_i.lfo_value;
      bypass_q <= !in_active;
      last_q   <= ({1'b0, in_i.channel} == cfg.act - 1'b1);
      sweep_q  <= swp_prod[vmd_pkg::FRAC_W +: vmd_pkg::SWEEP_W];
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= scl_prod[(vmd_pkg::FRAC_W - 1) +: vmd_pkg::SCALED_W];
    end
    if (state_q == ST_DELAY) begin
      if (dly < DLY_LO) begin
        d_q <= POS_W'(1);
        f_q <= '0;
      end else if (dly > DLY_HI) begin
        d_q <= POS_W'(MAX_DELAY - 1);
        f_q <= '0;
      end else begin
        d_q <= dly[vmd_pkg::FRAC_W +: POS_W];
        f_q <= dly[vmd_pkg::FRAC_W-1:0];
      end
    end
    if (state_q == ST_MUL) begin
      a_q    <= rd_a;
      prod_q <= prod;
    end
    if (out_load) begin
      out_data_q <= res;
    end
  end

  `VMD_ASSERT_NEXT(a_clear_resets_wp, cfg.clear, clr_busy_q && (wp_q == '0), "clear did not reset write position")
  `VMD_ASSERT_NEXT(a_wp_hold, (state_q != ST_OUT) && !cfg.clear, $stable(wp_q), "write position moved outside frame end")
  `VMD_ASSERT(a_delay_range, (state_q == ST_ADDR) |-> (d_q != '0) && (d_q <= POS_W'(MAX_DELAY - 1)), "delay out of range")
  `VMD_ASSERT_NEXT(a_out_source, !out_valid_q && (state_q != ST_OUT), !out_valid_q, "result without transfer")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for vibrato_modulated_delay_core: random bursty sample traffic,
// an inline model of the modulated delay line, and APB register phases.
// Depends on vmd_pkg and the vmd_in_if / vmd_out_if interfaces.
module tb;

  localparam int unsigned DLY_LEN = vmd_pkg::MAX_DELAY_DEF;
  localparam int unsigned N_CH    = vmd_pkg::MAX_CHANNELS_DEF;
  localparam int unsigned CYC_LIMIT = 1_500_000;
  localparam logic [vmd_pkg::RIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [vmd_pkg::DATA_W-1:0] sample;
    logic        [vmd_pkg::CHAN_W-1:0] chan;
    logic signed [vmd_pkg::LFO_W-1:0]  lfo;
  } smp_item_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [vmd_pkg::PADDR_W-1:0] paddr;
  logic [vmd_pkg::PDATA_W-1:0] pwdata;
  logic [vmd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  vmd_in_if  in_ch ();
  vmd_out_if out_ch ();

  vibrato_modulated_delay_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's registers and delay memory
  logic signed [vmd_pkg::DATA_W-1:0] delay_mem [N_CH][DLY_LEN];
  int unsigned wr_pos;
  logic [vmd_pkg::SR_W-1:0]    rate_r;
  logic [vmd_pkg::CNT_W-1:0]   chan_cnt_r;
  logic [vmd_pkg::DEPTH_W-1:0] depth_r;

  smp_item_t sample_feed_q[$];
  logic [vmd_pkg::DATA_W-1:0] vib_out_q[$];

  int n_fail;
  int unsigned cyc;
  logic in_took;
  int unsigned gap_left, burst_left;
  int unsigned rdy_left;
  logic [15:0] stall_pat;
  logic [3:0] rdy_pos;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void wipe_delay();
    foreach (delay_mem[c, i]) delay_mem[c][i] = '0;
    wr_pos = 0;
  endfunction

  function automatic int unsigned active_count();
    return (chan_cnt_r < N_CH) ? int'(chan_cnt_r) : N_CH;
  endfunction

  function automatic logic [vmd_pkg::DATA_W-1:0] vibrato_predict(
      logic signed [vmd_pkg::DATA_W-1:0] x,
      logic [vmd_pkg::CHAN_W-1:0] ch,
      logic signed [vmd_pkg::LFO_W-1:0] lfo);
    longint base, sweep, scaled, dly, ua, ub, acc, y;
    int unsigned nact, wp, dint, frac, p1, p2;
    nact = active_count();
    if (ch >= nact) return x;
    wp = wr_pos;
    delay_mem[ch][wp] = x;
    base = (longint'(rate_r) * 65536) / 200;
    sweep = (base * longint'(depth_r)) >>> 16;
    scaled = (sweep * (longint'(lfo) + 32768)) >>> 15;
    dly = base + scaled - sweep;
    if (dly < 64'sd65536) dly = 64'sd65536;
    if (dly > longint'(DLY_LEN - 1) * 65536) dly = longint'(DLY_LEN - 1) * 65536;
    dint = int'(dly >>> 16);
    frac = int'(dly & 64'hFFFF);
    p1 = (wp + DLY_LEN - dint) % DLY_LEN;
    p2 = (p1 + DLY_LEN - 1) % DLY_LEN;
    ua = longint'(delay_mem[ch][p1]) + 8388608;
    ub = longint'(delay_mem[ch][p2]) + 8388608;
    acc = ua * (65536 - frac) + ub * frac + 32768;
    y = (acc >>> 16) - 8388608;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    if (ch + 1 == nact) wr_pos = (wp + 1) % DLY_LEN;
    return y[vmd_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [vmd_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(vmd_pkg::DATA_W-1){1'b1}}};
      1: return {1'b1, {(vmd_pkg::DATA_W-1){1'b0}}};
      2: return vmd_pkg::DATA_W'($signed($urandom_range(0, 64)) - 32);
      default: return vmd_pkg::DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [vmd_pkg::LFO_W-1:0] pick_lfo();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return vmd_pkg::LFO_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 4);
    return $urandom_range(5, 30);
  endfunction

  function automatic void feed(logic signed [vmd_pkg::DATA_W-1:0] s,
                               logic [vmd_pkg::CHAN_W-1:0] c,
                               logic signed [vmd_pkg::LFO_W-1:0] l);
    sample_feed_q.push_back('{sample: s, chan: c, lfo: l});
  endfunction

  // mostly complete frames in channel order, the rest stray channels
  task automatic load_random(input int n);
    int made;
    int unsigned nact;
    logic signed [vmd_pkg::LFO_W-1:0] lfo;
    made = 0;
    nact = active_count();
    while (made < n) begin
      if (nact != 0 && $urandom_range(0, 9) < 8) begin
        lfo = pick_lfo();
        for (int k = 0; k < nact; k++) begin
          feed(pick_sample(), vmd_pkg::CHAN_W'(k),
               ($urandom_range(0, 7) == 0) ? pick_lfo() : lfo);
        end
        made += nact;
      end else begin
        feed(pick_sample(), vmd_pkg::CHAN_W'($urandom_range(0, N_CH - 1)), pick_lfo());
        made++;
      end
    end
  endtask

  task automatic reg_access(input logic [vmd_pkg::RIDX_W-1:0] idx, input bit wr,
                            input logic [vmd_pkg::PDATA_W-1:0] wdat,
                            output logic [vmd_pkg::PDATA_W-1:0] rdat);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdat;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdat = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_write(input logic [vmd_pkg::RIDX_W-1:0] idx,
                           input logic [vmd_pkg::PDATA_W-1:0] val);
    logic [vmd_pkg::PDATA_W-1:0] unused;
    reg_access(idx, 1'b1, val, unused);
    case (idx)
      vmd_pkg::REG_SAMPLE_RATE: begin
        if (val[vmd_pkg::SR_W-1:0] != rate_r) begin
          rate_r = val[vmd_pkg::SR_W-1:0];
          wipe_delay();
        end
      end
      vmd_pkg::REG_CHANNEL_COUNT: begin
        if (val[vmd_pkg::CNT_W-1:0] != chan_cnt_r) begin
          chan_cnt_r = val[vmd_pkg::CNT_W-1:0];
          wipe_delay();
        end
      end
      vmd_pkg::REG_DEPTH: depth_r = val[vmd_pkg::DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    logic [vmd_pkg::PDATA_W-1:0] got, want;
    logic [vmd_pkg::RIDX_W-1:0] idx;
    for (idx = vmd_pkg::REG_SAMPLE_RATE; idx <= vmd_pkg::REG_DEPTH; idx++) begin
      case (idx)
        vmd_pkg::REG_SAMPLE_RATE:   want = vmd_pkg::PDATA_W'(rate_r);
        vmd_pkg::REG_CHANNEL_COUNT: want = vmd_pkg::PDATA_W'(chan_cnt_r);
        default:                    want = vmd_pkg::PDATA_W'(depth_r);
      endcase
      reg_access(idx, 1'b0, '0, got);
      if (got !== want) begin
        $display("%0t: register %0d read expected %h actual %h", $time, idx, want, got);
        n_fail++;
      end
    end
  endtask

  // wait for all transfers to drain, then cover the pipeline latency
  task automatic settle();
    @(negedge clk);
    while (sample_feed_q.size() != 0 || in_ch.valid || vib_out_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    smp_item_t nx;
    logic nv;
    nx = '{sample: in_ch.sample_in, chan: in_ch.channel, lfo: in_ch.lfo_value};
    nv = in_ch.valid;
    if (rst_n && (!in_ch.valid || in_took)) begin
      nv = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (sample_feed_q.size() != 0) begin
        nx = sample_feed_q.pop_front();
        nv = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = pick_gap();
        end
      end
    end
    in_ch.valid     <= nv;
    in_ch.sample_in <= nx.sample;
    in_ch.channel   <= nx.chan;
    in_ch.lfo_value <= nx.lfo;
  end

  // output stall pattern
  always @(negedge clk) begin
    if (rdy_left == 0) begin
      rdy_left = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom & $urandom);
      endcase
    end else begin
      rdy_left--;
    end
    out_ch.ready <= stall_pat[rdy_pos];
    rdy_pos = rdy_pos + 1'b1;
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    logic [vmd_pkg::DATA_W-1:0] want;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      vib_out_q.push_back(vibrato_predict(in_ch.sample_in, in_ch.channel, in_ch.lfo_value));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vib_out_q.size() == 0) begin
        $display("%0t: sample_out expected none actual %h", $time, out_ch.sample_out);
        n_fail++;
      end else begin
        want = vib_out_q.pop_front();
        if (out_ch.sample_out !== want) begin
          $display("%0t: sample_out expected %h actual %h", $time, want, out_ch.sample_out);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    n_fail = 0;
    cyc = 0;
    in_took = 1'b0;
    gap_left = 0;
    burst_left = 1;
    rdy_left = 0;
    stall_pat = '1;
    rdy_pos = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.channel = '0;
    in_ch.lfo_value = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rate_r = vmd_pkg::SAMPLE_RATE_RST;
    chan_cnt_r = vmd_pkg::CHANNEL_COUNT_RST;
    depth_r = vmd_pkg::DEPTH_RST;
    wipe_delay();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: extremes, inactive channels, out-of-order channels
    check_regs();
    feed(24'sh7FFFFF, 3'd0, 16'sh7FFF);
    feed(24'sh800000, 3'd1, 16'sh7FFF);
    feed(24'sh800000, 3'd0, 16'sh8000);
    feed(24'sh7FFFFF, 3'd1, 16'sh8000);
    feed(24'sh000000, 3'd0, 16'sh0000);
    feed(-24'sd1,     3'd1, -16'sd1);
    feed(24'sh7FFFFF, 3'd2, 16'sh0000);
    feed(24'sh800000, 3'd7, 16'sh8000);
    feed(24'sh555555, 3'd0, 16'sh5555);
    feed(24'shAAAAAA, 3'd1, 16'shAAAA);
    feed(24'sh000123, 3'd1, 16'sh0000);
    feed(24'sh000456, 3'd0, 16'sh7FFF);
    feed(24'sh000789, 3'd0, 16'sh8000);
    feed(24'sh7FFFFF, 3'd1, 16'sh4000);
    feed(24'sh123456, 3'd5, 16'sh1234);
    load_random(100);
    settle();

    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'd8000);
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'd1);
    reg_write(vmd_pkg::REG_DEPTH, 32'd65536);
    check_regs();
    load_random(100);
    settle();

    // zero rate: delay pinned at one sample
    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'd0);
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'd8);
    reg_write(vmd_pkg::REG_DEPTH, 32'd0);
    check_regs();
    load_random(100);
    settle();

    // top of every register: count above eight, depth above one
    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'((1 << vmd_pkg::SR_W) - 1));
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'((1 << vmd_pkg::CNT_W) - 1));
    reg_write(vmd_pkg::REG_DEPTH, 32'((1 << vmd_pkg::DEPTH_W) - 1));
    check_regs();
    load_random(80);
    settle();

    // no active channels: everything passes through
    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'd192000);
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'd0);
    reg_write(vmd_pkg::REG_DEPTH, 32'($urandom_range(0, (1 << vmd_pkg::DEPTH_W) - 1)));
    reg_write(REG_UNUSED, $urandom);
    check_regs();
    load_random(40);
    settle();

    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'd16000);
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'd3);
    reg_write(vmd_pkg::REG_DEPTH, 32'($urandom_range(0, (1 << vmd_pkg::DEPTH_W) - 1)));
    check_regs();
    load_random(100);
    settle();

    // rewriting the same rate and count must keep the delay contents
    reg_write(vmd_pkg::REG_SAMPLE_RATE, 32'd16000);
    reg_write(vmd_pkg::REG_CHANNEL_COUNT, 32'd3);
    reg_write(vmd_pkg::REG_DEPTH, 32'd8000);
    check_regs();
    load_random(100);
    settle();

    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/vmd_pkg.sv
design/vmd_if.sv
design/vmd_store.sv
design/vmd_cfg.sv
design/vibrato_modulated_delay_core.sv
bench/tb.sv
